[design/assert_macros.svh]
// Assertion helpers; the body is empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PTX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PTX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTX_ASSERT_IMP(lbl, ante, cons, msg)
`define PTX_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[design/ptx_pkg.sv]
package ptx_pkg;

    localparam int TEX_WORDS       = 65536;
    localparam int TEX_AW          = $clog2(TEX_WORDS);
    localparam int UV_FRAC_BITS    = 22;
    localparam int DEPTH_FRAC_BITS = 28;
    localparam int SHADE_SHIFT     = DEPTH_FRAC_BITS - UV_FRAC_BITS;

    // command codes
    typedef enum logic [3:0] {
        F_LOAD   = 4'd0,
        F_LEFT   = 4'd1,
        F_RIGHT  = 4'd2,
        F_SWAP   = 4'd3,
        F_SPAN   = 4'd4,
        F_SHADE  = 4'd5,
        F_STEPX  = 4'd6,
        F_STEPL  = 4'd7,
        F_STEPR  = 4'd8,
        F_TEXWR  = 4'd9
    } t_func;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PITCH  = 2'd2;
    localparam logic [1:0] CFG_CLAMP  = 2'd3;

    // state word map
    localparam logic [4:0] A_U  = 5'd0;
    localparam logic [4:0] A_V  = 5'd3;
    localparam logic [4:0] A_EV = 5'd6;
    localparam logic [4:0] A_ED = 5'd10;
    localparam logic [4:0] A_SV = 5'd14;
    localparam logic [4:0] A_SD = 5'd16;
    localparam int         STATE_WORDS = 18;

    typedef enum logic [3:0] {
        S_IDLE, S_RDX, S_RDY, S_EXE, S_DIV, S_MUL, S_W1, S_W2, S_NEXT,
        S_ADDR, S_TEX, S_MOD
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

endpackage

[design/ptx_div.sv]
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero
module ptx_div
    import ptx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy, r_done, r_neg, r_zero;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_den;
    logic [32:0] rem_sh;
    logic        fits;

    assign rem_sh = {r_rem, r_quo[31]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring shift-subtract on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg  <= i_req.dividend[31] ^ i_req.divisor[31];
            r_zero <= i_req.divisor == '0;
            r_rem  <= '0;
            r_quo  <= i_req.dividend[31] ? -i_req.dividend : i_req.dividend;
            r_den  <= i_req.divisor[31] ? -i_req.divisor : i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_quo <= {r_quo[30:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_zero ? '0 : (r_neg ? -r_quo : r_quo);

endmodule

[design/perspective_texture_interpolator_top.sv]
// Perspective texture interpolator. Commands arrive one at a time and are
// worked through a sequencer that reads, modifies and writes back a small
// state word memory (vertex u/z v/z, edges, span) through a registered read.
// Texel writes, unused codes and load or edge commands that name vertex 3 are
// done on acceptance without leaving idle; swap exchanges fewer words when
// either vertex index is 3; vertex load, edge setup, span setup with a positive
// span and shade use the shared bit-serial divider (two quotients per command),
// while span setup with a span of zero or less and step commands do not.
// The shade result sits in an output register, so the next command is taken
// while it waits. A stalled shade result holds the sequencer at the next shade's output step.
`include "assert_macros.svh"
module perspective_texture_interpolator_top
    import ptx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [3:0]   s_tuser,   // func
    // vertex_a[1:0], vertex_b[3:2], amount[17:4], tex_u[26:18], tex_v[35:27],
    // vertex_depth[51:36], inverse_depth[80:52], in_color[104:81],
    // texel_address[120:105], zero fill above
    input  logic [127:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // shaded_color[23:0], texel_u[55:24], texel_v[87:56]
    output logic [87:0]  m_tdata,
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [12:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [12:0] r_width, r_height, r_pitch;
    logic        r_clamp;

    t_func        r_func;
    logic [1:0]   r_va, r_vb;
    logic [13:0]  r_amt;
    logic [8:0]   r_tu, r_tv;
    logic [15:0]  r_depth;
    logic [28:0]  r_invz;
    logic [23:0]  r_color;
    logic [2:0]   r_k;

    logic [31:0] r_x, r_y, r_q, r_prod, r_u, r_v, r_rdata;
    logic [23:0] r_tex;
    logic        r_ovalid;
    logic [87:0] r_out;

    logic [31:0] st_mem [STATE_WORDS];
    logic [23:0] tex_mem [TEX_WORDS];

    logic        s_acc, div_done, leave_mod;
    logic [31:0] div_q, amt32;
    t_div_req    div_req;
    t_func       in_func;
    logic        need_div, need_mul, is_shade, last_k, amt_pos;
    logic [2:0]  k_limit;
    logic [4:0]  ax, ay, rd_addr, w1_addr, w2_addr, uv_base;
    logic [31:0] w1_data, w2_data;
    logic        w1_en, w2_en;
    logic [4:0]  edge_base;
    logic [31:0] u_c, v_c;
    logic [TEX_AW-1:0] tex_raddr;
    logic [23:0] shaded;

    assign in_func   = t_func'(s_tuser);
    assign s_tready  = r_state == S_IDLE;
    assign s_acc     = s_tvalid && s_tready;
    assign o_cfg_ready = 1'b1;
    assign amt32     = {{18{r_amt[13]}}, r_amt};
    assign amt_pos   = !r_amt[13] && r_amt != '0;
    assign is_shade  = r_func == F_SHADE;
    assign leave_mod = !r_ovalid || m_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd256;
            r_height <= 13'd256;
            r_pitch  <= 13'd256;
            r_clamp  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_PITCH:  r_pitch  <= i_cfg_data;
                CFG_CLAMP:  r_clamp  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // per-command decode
    always_comb begin
        edge_base = (r_func == F_LEFT || r_func == F_STEPL) ? 5'd0 : 5'd2;
        uv_base   = (r_k[0]) ? A_V : A_U;
        k_limit   = 3'd2;
        need_div  = 1'b0;
        need_mul  = 1'b0;
        ax = A_U;
        ay = A_U;
        case (r_func)
            F_LOAD: need_div = 1'b1;
            F_LEFT, F_RIGHT: begin
                need_div = 1'b1;
                ax = uv_base + {3'b0, r_va};
                ay = uv_base + {3'b0, r_vb};
            end
            F_SWAP: begin
                k_limit = (r_va == 2'd3 || r_vb == 2'd3) ? 3'd4 : 3'd6;
                case (r_k)
                    3'd0: begin ax = A_EV;       ay = A_EV + 5'd2; end
                    3'd1: begin ax = A_EV + 5'd1; ay = A_EV + 5'd3; end
                    3'd2: begin ax = A_ED;       ay = A_ED + 5'd2; end
                    3'd3: begin ax = A_ED + 5'd1; ay = A_ED + 5'd3; end
                    3'd4: begin ax = A_U + {3'b0, r_va}; ay = A_U + {3'b0, r_vb}; end
                    default: begin ax = A_V + {3'b0, r_va}; ay = A_V + {3'b0, r_vb}; end
                endcase
            end
            F_SPAN: begin
                need_div = amt_pos;
                ax = A_EV + {4'b0, r_k[0]};
                ay = A_EV + 5'd2 + {4'b0, r_k[0]};
            end
            F_SHADE: begin
                need_div = 1'b1;
                ax = A_SV + {4'b0, r_k[0]};
            end
            F_STEPX: begin
                need_mul = 1'b1;
                ax = A_SD + {4'b0, r_k[0]};
                ay = A_SV + {4'b0, r_k[0]};
            end
            F_STEPL, F_STEPR: begin
                need_mul = 1'b1;
                ax = A_ED + edge_base + {4'b0, r_k[0]};
                ay = A_EV + edge_base + {4'b0, r_k[0]};
            end
            default: ;
        endcase
        last_k = r_k == k_limit - 3'd1;
    end

    // write-back selection
    always_comb begin
        w1_en   = 1'b0;
        w2_en   = 1'b0;
        w1_addr = ax;
        w2_addr = ax;
        w1_data = r_x;
        w2_data = r_q;
        case (r_func)
            F_LOAD: begin
                w1_en   = 1'b1;
                w1_addr = uv_base + {3'b0, r_va};
                w1_data = r_q;
            end
            F_LEFT, F_RIGHT: begin
                w1_en = 1'b1;
                w2_en = 1'b1;
                w1_addr = A_EV + edge_base + {4'b0, r_k[0]};
                w2_addr = A_ED + edge_base + {4'b0, r_k[0]};
            end
            F_SPAN: begin
                w1_en = 1'b1;
                w2_en = 1'b1;
                w1_addr = A_SV + {4'b0, r_k[0]};
                w2_addr = A_SD + {4'b0, r_k[0]};
                w2_data = amt_pos ? r_q : r_y - r_x;
            end
            F_SWAP: begin
                w1_en = 1'b1;
                w2_en = 1'b1;
                w1_addr = ay;
                w2_addr = ax;
                w2_data = r_y;
            end
            F_STEPX, F_STEPL, F_STEPR: begin
                w1_en   = 1'b1;
                w1_addr = ay;
                w1_data = r_y + r_prod;
            end
            default: ;
        endcase
    end

    // divider operands, issued from the execute state
    always_comb begin
        div_req.start    = r_state == S_EXE && need_div;
        div_req.dividend = r_rdata - r_x;
        div_req.divisor  = amt32;
        case (r_func)
            F_LOAD: begin
                div_req.dividend = 32'(r_k[0] ? r_tv : r_tu) << UV_FRAC_BITS;
                div_req.divisor  = {16'b0, r_depth};
            end
            F_SHADE: begin
                div_req.dividend = r_x << SHADE_SHIFT;
                div_req.divisor  = {3'b0, r_invz};
            end
            default: ;
        endcase
    end

    ptx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (in_func)
                        F_LOAD:
                            n_state = (s_tdata[1:0] != 2'd3) ? S_RDX : S_IDLE;
                        F_LEFT, F_RIGHT:
                            n_state = (s_tdata[1:0] != 2'd3 && s_tdata[3:2] != 2'd3)
                                      ? S_RDX : S_IDLE;
                        F_SWAP, F_SPAN, F_SHADE, F_STEPX, F_STEPL, F_STEPR:
                            n_state = S_RDX;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RDX: n_state = S_RDY;
            S_RDY: n_state = S_EXE;
            S_EXE: n_state = need_div ? S_DIV : (need_mul ? S_MUL : S_W1);
            S_DIV: if (div_done) n_state = is_shade ? S_NEXT : S_W1;
            S_MUL: n_state = S_W1;
            S_W1:  n_state = S_W2;
            S_W2:  n_state = S_NEXT;
            S_NEXT: n_state = last_k ? (is_shade ? S_ADDR : S_IDLE) : S_RDX;
            S_ADDR: n_state = S_TEX;
            S_TEX:  n_state = S_MOD;
            S_MOD:  if (leave_mod) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // memory read address
    always_comb begin
        rd_addr = (r_state == S_RDX) ? ax : ay;
    end

    // state word memory: all zero after reset, cleared in flip-flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STATE_WORDS; i++) st_mem[i] <= '0;
        end else begin
            if (r_state == S_W1 && w1_en) st_mem[w1_addr] <= w1_data;
            if (r_state == S_W2 && w2_en) st_mem[w2_addr] <= w2_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= st_mem[rd_addr];
    end

    // clamp from above and fetch address
    always_comb begin
        u_c = (r_clamp && $signed(r_u) > $signed({19'b0, r_width}))  ? {19'b0, r_width}  : r_u;
        v_c = (r_clamp && $signed(r_v) > $signed({19'b0, r_height})) ? {19'b0, r_height} : r_v;
        tex_raddr = TEX_AW'(r_prod + r_u);
    end

    // texture memory
    always_ff @(posedge i_clk) begin
        if (s_acc && in_func == F_TEXWR) tex_mem[s_tdata[105 +: TEX_AW]] <= s_tdata[104:81];
        r_tex <= tex_mem[tex_raddr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_func  <= in_func;
            r_va    <= s_tdata[1:0];
            r_vb    <= s_tdata[3:2];
            r_amt   <= s_tdata[17:4];
            r_tu    <= s_tdata[26:18];
            r_tv    <= s_tdata[35:27];
            r_depth <= s_tdata[51:36];
            r_invz  <= s_tdata[80:52];
            r_color <= s_tdata[104:81];
            r_k     <= '0;
        end
        case (r_state)
            S_RDY: r_x <= r_rdata;
            S_EXE: r_y <= r_rdata;
            S_DIV: begin
                if (div_done) begin
                    r_q <= div_q;
                    if (is_shade && !r_k[0]) r_u <= div_q;
                    if (is_shade &&  r_k[0]) r_v <= div_q;
                end
            end
            S_MUL:  r_prod <= r_x * amt32;
            S_NEXT: r_k <= r_k + 3'd1;
            S_ADDR: begin
                r_u    <= u_c;
                r_v    <= v_c;
                r_prod <= v_c * {19'b0, r_pitch};
            end
            default: ;
        endcase
    end

    // modulate texel by pixel colour
    always_comb begin
        shaded[23:16] = 8'((16'(r_tex[23:16]) * 16'(r_color[23:16])) >> 8);
        shaded[15:8]  = 8'((16'(r_tex[15:8])  * 16'(r_color[15:8]))  >> 8);
        shaded[7:0]   = 8'((16'(r_tex[7:0])   * 16'(r_color[7:0]))   >> 8);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_MOD && leave_mod) begin
            r_ovalid <= 1'b1;
        end else if (m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOD && leave_mod) r_out <= {r_v, r_u, shaded};
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_out;

    `PTX_ASSERT_IMP(a_div_start, div_req.start, r_state == S_EXE, "divider started outside execute")
    `PTX_ASSERT_IMP(a_div_done, div_done, r_state == S_DIV, "quotient arrived unexpectedly")
    `PTX_ASSERT_NXT(a_out_load, r_state == S_MOD && leave_mod, m_tvalid, "shade result lost")

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import ptx_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 3000;

    typedef struct packed {
        logic [3:0]  func;
        logic [1:0]  va;
        logic [1:0]  vb;
        logic [13:0] amt;
        logic [8:0]  tu;
        logic [8:0]  tv;
        logic [15:0] depth;
        logic [28:0] invz;
        logic [23:0] color;
        logic [15:0] taddr;
    } cmd_t;

    typedef struct packed {
        logic [23:0] rgb;
        logic [31:0] u;
        logic [31:0] v;
    } shade_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [3:0]   s_tuser = '0;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [12:0]  i_cfg_data = '0;

    perspective_texture_interpolator_top uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] uz [3];
    logic [31:0] vz [3];
    logic [31:0] ev [4];
    logic [31:0] ed [4];
    logic [31:0] sv [2];
    logic [31:0] sd [2];
    logic [23:0] tex_mem [TEX_WORDS];
    bit          tex_ok [TEX_WORDS];
    logic [12:0] tex_w = 13'd256, tex_h = 13'd256, tex_p = 13'd256;
    logic        clamp_on = 1'b1;

    cmd_t   cmd_q [$];
    shade_t shade_q [$];
    int     errors = 0;
    int     cycles = 0;
    int     n_shades = 0;
    int     n_cmds = 0;
    logic   no_idle = 1'b0;
    logic   src_hold = 1'b0;
    logic   hold_kick = 1'b0;
    int     hold_cnt = 0;
    int     src_gap = 0;
    int     rx_gap = 0;
    int     rx_next;
    cmd_t   drv_cmd;

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
        if (b == 0) return 32'd0;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
        return 32'($signed(a) / $signed(b));
    endfunction

    function automatic logic [127:0] pack_cmd(cmd_t c);
        return {7'd0, c.taddr, c.color, c.invz, c.depth, c.tv, c.tu, c.amt, c.vb, c.va};
    endfunction

    // advance predictor state by one queued command
    task automatic model_cmd(logic [3:0] f, logic [127:0] d);
        logic [1:0]  a, b;
        logic [31:0] amt, u, v, diff, t;
        logic [23:0] tx;
        logic [23:0] col;
        int          base;
        shade_t      r;
        cmd_t        fill;
        a = d[1:0];
        b = d[3:2];
        amt = {{18{d[17]}}, d[17:4]};
        col = d[104:81];
        case (t_func'(f))
            F_LOAD: begin
                if (a < 3) begin
                    uz[a] = sdiv(32'(d[26:18]) << UV_FRAC_BITS, 32'(d[51:36]));
                    vz[a] = sdiv(32'(d[35:27]) << UV_FRAC_BITS, 32'(d[51:36]));
                end
            end
            F_LEFT, F_RIGHT: begin
                base = (t_func'(f) == F_LEFT) ? 0 : 2;
                if (a < 3 && b < 3) begin
                    ev[base] = uz[a];
                    ev[base+1] = vz[a];
                    ed[base] = sdiv(uz[b] - uz[a], amt);
                    ed[base+1] = sdiv(vz[b] - vz[a], amt);
                end
            end
            F_SWAP: begin
                for (int k = 0; k < 2; k++) begin
                    t = ev[k]; ev[k] = ev[k+2]; ev[k+2] = t;
                    t = ed[k]; ed[k] = ed[k+2]; ed[k+2] = t;
                end
                if (a < 3 && b < 3) begin
                    t = uz[a]; uz[a] = uz[b]; uz[b] = t;
                    t = vz[a]; vz[a] = vz[b]; vz[b] = t;
                end
            end
            F_SPAN: begin
                for (int k = 0; k < 2; k++) begin
                    diff = ev[k+2] - ev[k];
                    sv[k] = ev[k];
                    sd[k] = ($signed(amt) > 0) ? sdiv(diff, amt) : diff;
                end
            end
            F_SHADE: begin
                u = sdiv(sv[0] << SHADE_SHIFT, 32'(d[80:52]));
                v = sdiv(sv[1] << SHADE_SHIFT, 32'(d[80:52]));
                if (clamp_on) begin
                    if ($signed(u) > $signed(32'(tex_w))) u = 32'(tex_w);
                    if ($signed(v) > $signed(32'(tex_h))) v = 32'(tex_h);
                end
                t = v * 32'(tex_p) + u;
                // first fetch of this word: write it just ahead of the shade
                if (!tex_ok[t[TEX_AW-1:0]]) begin
                    fill = '0;
                    fill.func = F_TEXWR;
                    fill.taddr = t[TEX_AW-1:0];
                    fill.color = 24'($urandom);
                    tex_mem[t[TEX_AW-1:0]] = fill.color;
                    tex_ok[t[TEX_AW-1:0]] = 1'b1;
                    cmd_q.push_back(fill);
                end
                tx = tex_mem[t[TEX_AW-1:0]];
                r.rgb[23:16] = 8'((16'(tx[23:16]) * 16'(col[23:16])) >> 8);
                r.rgb[15:8]  = 8'((16'(tx[15:8]) * 16'(col[15:8])) >> 8);
                r.rgb[7:0]   = 8'((16'(tx[7:0]) * 16'(col[7:0])) >> 8);
                r.u = u;
                r.v = v;
                shade_q.push_back(r);
                n_shades++;
            end
            F_STEPX: begin
                sv[0] = sv[0] + sd[0] * amt;
                sv[1] = sv[1] + sd[1] * amt;
            end
            F_STEPL, F_STEPR: begin
                base = (t_func'(f) == F_STEPL) ? 0 : 2;
                ev[base] = ev[base] + ed[base] * amt;
                ev[base+1] = ev[base+1] + ed[base+1] * amt;
            end
            F_TEXWR: begin
                tex_mem[d[120:105]] = col;
                tex_ok[d[120:105]] = 1'b1;
            end
            default: ;
        endcase
    endtask

    // predict and queue one command
    task automatic push_cmd(cmd_t c);
        model_cmd(c.func, pack_cmd(c));
        cmd_q.push_back(c);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0 && !src_hold) begin
                drv_cmd = cmd_q.pop_front();
                s_tuser <= drv_cmd.func;
                s_tdata <= pack_cmd(drv_cmd);
                s_tvalid <= 1'b1;
                src_gap <= no_idle ? 0 : $urandom_range(0, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // count accepted commands
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            n_cmds++;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_kick) hold_cnt <= LONG_HOLD;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // result receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_next = no_idle ? 0 : $urandom_range(0, 9);
                if (shade_q.size() == 0) begin
                    report("result with nothing pending", m_tdata[31:0], 32'd0);
                end else begin
                    shade_t e;
                    e = shade_q.pop_front();
                    if (m_tdata[23:0] !== e.rgb) report("shaded_color", m_tdata[23:0], e.rgb);
                    if (m_tdata[55:24] !== e.u) report("texel_u", m_tdata[55:24], e.u);
                    if (m_tdata[87:56] !== e.v) report("texel_v", m_tdata[87:56], e.v);
                end
            end else if (rx_gap != 0) begin
                rx_next = rx_gap - 1;
            end else begin
                rx_next = 0;
            end
            rx_gap <= rx_next;
            m_tready <= (rx_next == 0) && (hold_cnt <= 1) && !hold_kick;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic cmd_t rand_cmd(logic [3:0] f);
        cmd_t c;
        c.func  = f;
        c.va    = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        c.vb    = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:       c.amt = 14'($urandom_range(0, 8192) - 4096);
            1:       c.amt = 14'($urandom_range(0, 40) - 8);
            default: c.amt = 14'($urandom_range(1, 12));
        endcase
        c.tu    = 9'($urandom_range(0, 511));
        c.tv    = 9'($urandom_range(0, 511));
        c.depth = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 32));
        case ($urandom_range(0, 3))
            0:       c.invz = 29'($urandom_range(1, 1 << 28));
            1:       c.invz = 29'((1 << 28) - $urandom_range(0, 1000));
            default: c.invz = 29'((1 << 28) / $urandom_range(1, 256));
        endcase
        c.color = 24'($urandom);
        c.taddr = 16'($urandom);
        return c;
    endfunction

    task automatic push_op(logic [3:0] f);
        push_cmd(rand_cmd(f));
    endtask

    // one triangle: vertices, edges, then rows of shaded spans
    task automatic push_triangle(ref int issued);
        cmd_t c;
        int rows, pix;
        for (int k = 0; k < 3; k++) begin
            c = rand_cmd(F_LOAD);
            c.va = 2'(k);
            push_cmd(c);
        end
        c = rand_cmd(F_LEFT);  c.va = 0; c.vb = 1; c.amt = 14'($urandom_range(1, 8));
        push_cmd(c);
        c = rand_cmd(F_RIGHT); c.va = 0; c.vb = 2; c.amt = 14'($urandom_range(1, 8));
        push_cmd(c);
        if ($urandom_range(0, 3) == 0) push_op(F_SWAP);
        issued += 5;
        rows = $urandom_range(1, 4);
        for (int r = 0; r < rows; r++) begin
            c = rand_cmd(F_SPAN); c.amt = 14'($urandom_range(0, 16));
            push_cmd(c);
            pix = $urandom_range(1, 4);
            for (int p = 0; p < pix; p++) begin
                push_op(F_SHADE);
                c = rand_cmd(F_STEPX); c.amt = 14'($urandom_range(1, 2));
                push_cmd(c);
            end
            c = rand_cmd(F_STEPL); c.amt = 14'd1; push_cmd(c);
            c = rand_cmd(F_STEPR); c.amt = 14'd1; push_cmd(c);
            if ($urandom_range(0, 4) == 0) push_op(F_TEXWR);
            issued += 3 + 2 * pix;
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (cmd_q.size() != 0 || s_tvalid || shade_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write_all(logic [12:0] w, logic [12:0] h, logic [12:0] p, logic cl);
        logic [12:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{w, h, p, {12'd0, cl}};
        idx = '{CFG_WIDTH, CFG_HEIGHT, CFG_PITCH, CFG_CLAMP};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                CFG_WIDTH:  tex_w = vals[k];
                CFG_HEIGHT: tex_h = vals[k];
                CFG_PITCH:  tex_p = vals[k];
                CFG_CLAMP:  clamp_on = vals[k][0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_directed();
        cmd_t c;
        c = rand_cmd(F_TEXWR); c.taddr = 16'd0;     c.color = 24'hFFFFFF; push_cmd(c);
        c = rand_cmd(F_TEXWR); c.taddr = 16'hFFFF;  c.color = 24'h000000; push_cmd(c);
        c = rand_cmd(F_LOAD); c.va = 0; c.tu = 9'd511; c.tv = 9'd511; c.depth = 16'd1;
        push_cmd(c);
        c = rand_cmd(F_LOAD); c.va = 1; c.tu = 9'd0; c.tv = 9'd0; c.depth = 16'd0;
        push_cmd(c);
        c = rand_cmd(F_LOAD); c.va = 2; c.tu = 9'd300; c.tv = 9'd17; c.depth = 16'hFFFF;
        push_cmd(c);
        c = rand_cmd(F_LOAD); c.va = 3; push_cmd(c);
        c = rand_cmd(F_LEFT); c.va = 0; c.vb = 1; c.amt = 14'd0; push_cmd(c);
        c = rand_cmd(F_LEFT); c.va = 1; c.vb = 0; c.amt = 14'(-4096); push_cmd(c);
        c = rand_cmd(F_RIGHT); c.va = 0; c.vb = 2; c.amt = 14'd4096; push_cmd(c);
        c = rand_cmd(F_RIGHT); c.va = 3; c.vb = 1; push_cmd(c);
        c = rand_cmd(F_SPAN); c.amt = 14'd0; push_cmd(c);
        c = rand_cmd(F_SPAN); c.amt = 14'(-5); push_cmd(c);
        c = rand_cmd(F_SPAN); c.amt = 14'd3; push_cmd(c);
        c = rand_cmd(F_SHADE); c.invz = 29'd0; c.color = 24'hFFFFFF; push_cmd(c);
        c = rand_cmd(F_SHADE); c.invz = 29'(1 << 28); push_cmd(c);
        c = rand_cmd(F_SHADE); c.invz = 29'd1; c.color = 24'h000000; push_cmd(c);
        c = rand_cmd(F_STEPX); c.amt = 14'(-4096); push_cmd(c);
        c = rand_cmd(F_SHADE); push_cmd(c);
        c = rand_cmd(F_STEPL); c.amt = 14'd4096; push_cmd(c);
        c = rand_cmd(F_STEPR); c.amt = 14'(-1); push_cmd(c);
        c = rand_cmd(F_SWAP); c.va = 0; c.vb = 2; push_cmd(c);
        c = rand_cmd(F_SWAP); c.va = 3; c.vb = 1; push_cmd(c);
        c = rand_cmd(4'd15); push_cmd(c);
        c = rand_cmd(F_SPAN); c.amt = 14'd1; push_cmd(c);
        c = rand_cmd(F_SHADE); push_cmd(c);
    endtask

    // stimulus sequence
    initial begin
        int issued;
        logic [12:0] cw [5], ch [5], cp [5];
        logic        cc [5];
        cw = '{13'd256, 13'd1, 13'd4096, 13'($urandom_range(1, 4096)), 13'd4095};
        ch = '{13'd256, 13'd1, 13'd4096, 13'($urandom_range(1, 4096)), 13'd2730};
        cp = '{13'd256, 13'd1, 13'd4096, 13'($urandom_range(1, 4096)), 13'd5461};
        cc = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_directed();
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph != 0) cfg_write_all(cw[ph], ch[ph], cp[ph], cc[ph]);
            issued = 0;
            while (issued < 230) begin
                if (issued % 60 == 0) no_idle <= ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 6) == 0) begin
                    push_op(4'($urandom_range(0, 15)));
                    issued++;
                end else begin
                    push_triangle(issued);
                end
                while (cmd_q.size() > 20) @(posedge i_clk);
            end
            if (ph == 2) begin
                // receiver stalls long while the sender keeps offering shades
                hold_kick <= 1'b1;
                @(posedge i_clk);
                hold_kick <= 1'b0;
                no_idle <= 1'b1;
                for (int k = 0; k < 20; k++) push_op(F_SHADE);
                @(posedge i_clk);
                while (hold_cnt != 0) @(posedge i_clk);
                no_idle <= 1'b0;
            end
            wait_idle();
        end

        $display("covered %0d commands and %0d shaded pixels over 5 register settings",
                 n_cmds, n_shades);
        $display("including texel writes placed ahead of first fetches, a long result stall"
                 , " and idle drains");
        if (errors == 0 && shade_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
